>>> hdl/peer_learning_table_with_aging_assert.svh
// Assertion macros shared by the peer learning table modules.
`ifndef PEER_LEARNING_TABLE_WITH_AGING_ASSERT_SVH
`define PEER_LEARNING_TABLE_WITH_AGING_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on clk while rst_n is high.
`define PLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included.
`define PLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLT_ASSERT(lbl, prop, msg)
`define PLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/plt_pkg.sv
// Shared types and constants of the peer learning table.
`default_nettype none

package plt_pkg;

  // Request codes of an input item.
  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_ADD    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DISC_EN    = 3'd0;
  localparam logic [2:0] CFG_OWN_NONCE  = 3'd1;
  localparam logic [2:0] CFG_HELLO_PER  = 3'd2;
  localparam logic [2:0] CFG_IDLE_LIMIT = 3'd3;
  localparam logic [2:0] CFG_DISC_MAGIC = 3'd4;
  localparam logic [2:0] CFG_DATA_MAGIC = 3'd5;
  localparam logic [2:0] CFG_HELLO_LEN  = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [31:0] OWN_NONCE_RST  = 32'hA5A5_A5A5;
  localparam logic [15:0] HELLO_PER_RST  = 16'd60;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd900;
  localparam logic [9:0]  HELLO_LEN_RST  = 10'd12;

  // Packets shorter than this are rejected outright.
  localparam logic [9:0]  MIN_PACKET_LEN = 10'd12;
  localparam logic [15:0] COUNT_SAT      = 16'hFFFF;

  // Result action codes.
  typedef enum logic [3:0] {
    ACT_SHORT     = 4'd0,
    ACT_OWN_HELLO = 4'd1,
    ACT_NEW_PEER  = 4'd2,
    ACT_REFRESH   = 4'd3,
    ACT_DATA      = 4'd4,
    ACT_FULL      = 4'd5,
    ACT_UNKNOWN   = 4'd6,
    ACT_TICK      = 4'd7,
    ACT_PINNED    = 4'd8,
    ACT_ADD_FAIL  = 4'd9
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> hdl/plt_ctrl.sv
// Controller state machine of the peer learning table.
`default_nettype none
`include "peer_learning_table_with_aging_assert.svh"

module plt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output plt_pkg::ctrl_cmd_t     cmd
);
  import plt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign accept = start && (state_r == S_IDLE);

  // Next state: an accepted item is executed in the following cycle.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and the registered result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy        = (state_r == S_EXEC);
  assign out_valid   = out_valid_r;
  assign cmd.load    = accept;
  assign cmd.execute = (state_r == S_EXEC);

  `PLT_ASSERT(a_strobe_after_exec, out_valid |-> $past(state_r == S_EXEC), "strobe without execute")
  `PLT_ASSERT(a_accept_then_busy, accept |=> busy, "accepted item not executed")
  `PLT_ASSERT(a_single_strobe, out_valid |=> !out_valid, "result strobe held longer than one cycle")

endmodule

`default_nettype wire

>>> hdl/plt_datapath.sv
// Datapath of the peer learning table: configuration, peer entries and result registers.
`default_nettype none
`include "peer_learning_table_with_aging_assert.svh"

module plt_datapath #(
  parameter int PEER_SLOTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  plt_pkg::ctrl_cmd_t      cmd,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [31:0]        in_src_addr,
  input  wire logic [15:0]        in_src_port,
  input  wire logic [31:0]        in_first_word,
  input  wire logic [31:0]        in_third_word,
  input  wire logic [9:0]         in_packet_length,
  output logic [3:0]              out_action,
  output logic [2:0]              out_peer_index,
  output logic                    out_send_broadcast_hello,
  output logic [7:0]              out_expired_mask,
  output logic [3:0]              out_peer_count
);
  import plt_pkg::*;

  localparam int SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CW = $clog2(PEER_SLOTS + 1);

  // Configuration registers.
  logic        disc_en_r;
  logic [31:0] own_nonce_r;
  logic [15:0] hello_per_r;
  logic [15:0] idle_limit_r;
  logic [31:0] disc_magic_r;
  logic [31:0] data_magic_r;
  logic [9:0]  hello_len_r;

  // Captured input item.
  logic [1:0]  req_r;
  logic [31:0] addr_r;
  logic [15:0] port_r;
  logic [31:0] word0_r;
  logic [31:0] word2_r;
  logic [9:0]  len_r;

  // Peer entries and the hello timer.
  logic [PEER_SLOTS-1:0] used_r, used_nxt;
  logic [PEER_SLOTS-1:0] pinned_r, pinned_nxt;
  logic [15:0]           idle_r [PEER_SLOTS];
  logic [15:0]           idle_nxt [PEER_SLOTS];
  logic [31:0]           ent_addr_r [PEER_SLOTS];
  logic [15:0]           ent_port_r [PEER_SLOTS];
  logic [15:0]           timer_r, timer_nxt;

  // Result registers.
  action_t               act_r, act_nxt;
  logic [SW-1:0]         idx_r, idx_nxt;
  logic                  hello_r, hello_nxt;
  logic [PEER_SLOTS-1:0] expired_r, expired_nxt;
  logic [CW-1:0]         count_r, count_nxt;

  // Lookup and allocation.
  logic [PEER_SLOTS-1:0] hit_vec;
  logic                  hit_any, free_any;
  logic [SW-1:0]         hit_idx, free_idx;
  logic                  learn, learn_pinned, touch;
  logic [SW-1:0]         touch_idx;
  logic [15:0]           timer_inc;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_en_r    <= 1'b0;
      own_nonce_r  <= OWN_NONCE_RST;
      hello_per_r  <= HELLO_PER_RST;
      idle_limit_r <= IDLE_LIMIT_RST;
      disc_magic_r <= '0;
      data_magic_r <= '0;
      hello_len_r  <= HELLO_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISC_EN:    disc_en_r    <= cfg_data[0];
        CFG_OWN_NONCE:  own_nonce_r  <= cfg_data;
        CFG_HELLO_PER:  hello_per_r  <= cfg_data[15:0];
        CFG_IDLE_LIMIT: idle_limit_r <= cfg_data[15:0];
        CFG_DISC_MAGIC: disc_magic_r <= cfg_data;
        CFG_DATA_MAGIC: data_magic_r <= cfg_data;
        CFG_HELLO_LEN:  hello_len_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Capture the item on its transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      addr_r  <= in_src_addr;
      port_r  <= in_src_port;
      word0_r <= in_first_word;
      word2_r <= in_third_word;
      len_r   <= in_packet_length;
    end
  end

  // Parallel match against every used entry, and the lowest free slot.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      hit_vec[i] = used_r[i] && (ent_addr_r[i] == addr_r) && (ent_port_r[i] == port_r);
    end
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = SW'(i);
      if (!used_r[i]) free_idx = SW'(i);
    end
    hit_any  = |hit_vec;
    free_any = ~&used_r;
  end

  // Classification of the item.
  always_comb begin
    act_nxt      = ACT_UNKNOWN;
    idx_nxt      = '0;
    learn        = 1'b0;
    learn_pinned = 1'b0;
    touch        = 1'b0;
    touch_idx    = hit_idx;
    case (req_r)
      REQ_PACKET: begin
        if (len_r < MIN_PACKET_LEN) begin
          act_nxt = ACT_SHORT;
        end else if (word0_r == disc_magic_r) begin
          if ((len_r >= hello_len_r) && (word2_r == own_nonce_r)) begin
            act_nxt = ACT_OWN_HELLO;
          end else if (hit_any) begin
            act_nxt = ACT_REFRESH;
            idx_nxt = hit_idx;
            touch   = 1'b1;
          end else if (free_any) begin
            act_nxt = ACT_NEW_PEER;
            idx_nxt = free_idx;
            learn   = 1'b1;
          end else begin
            act_nxt = ACT_FULL;
          end
        end else if (word0_r == data_magic_r) begin
          if (hit_any) begin
            act_nxt = ACT_DATA;
            idx_nxt = hit_idx;
            touch   = 1'b1;
          end else if (free_any) begin
            act_nxt = ACT_DATA;
            idx_nxt = free_idx;
            learn   = 1'b1;
          end else begin
            act_nxt = ACT_FULL;
          end
        end else begin
          act_nxt = ACT_UNKNOWN;
        end
      end
      REQ_TICK: act_nxt = ACT_TICK;
      REQ_ADD: begin
        if (free_any) begin
          act_nxt      = ACT_PINNED;
          idx_nxt      = free_idx;
          learn        = 1'b1;
          learn_pinned = 1'b1;
        end else begin
          act_nxt = ACT_ADD_FAIL;
        end
      end
      default: act_nxt = ACT_UNKNOWN;
    endcase
  end

  // Hello timer on a tick.
  always_comb begin
    timer_inc = (timer_r != COUNT_SAT) ? timer_r + 16'd1 : timer_r;
    timer_nxt = timer_r;
    hello_nxt = 1'b0;
    if ((req_r == REQ_TICK) && disc_en_r) begin
      if (timer_inc >= hello_per_r) begin
        timer_nxt = '0;
        hello_nxt = 1'b1;
      end else begin
        timer_nxt = timer_inc;
      end
    end
  end

  // Entry updates: learning, refresh and ageing of unpinned peers.
  always_comb begin
    used_nxt    = used_r;
    pinned_nxt  = pinned_r;
    expired_nxt = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      idle_nxt[i] = idle_r[i];
      if (req_r == REQ_TICK) begin
        if (used_r[i] && !pinned_r[i]) begin
          idle_nxt[i] = (idle_r[i] != COUNT_SAT) ? idle_r[i] + 16'd1 : idle_r[i];
          if (idle_nxt[i] >= idle_limit_r) begin
            used_nxt[i]    = 1'b0;
            expired_nxt[i] = 1'b1;
          end
        end
      end else if (learn && (free_idx == SW'(i))) begin
        used_nxt[i]   = 1'b1;
        pinned_nxt[i] = learn_pinned;
        idle_nxt[i]   = '0;
      end else if (touch && (touch_idx == SW'(i))) begin
        idle_nxt[i] = '0;
      end
    end
  end

  // Number of used entries after the step.
  always_comb begin
    count_nxt = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      count_nxt = count_nxt + CW'(used_nxt[i]);
    end
  end

  // Entry state and timer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      pinned_r <= '0;
      timer_r  <= COUNT_SAT;
      for (int i = 0; i < PEER_SLOTS; i++) idle_r[i] <= '0;
    end else if (cmd.execute) begin
      used_r   <= used_nxt;
      pinned_r <= pinned_nxt;
      timer_r  <= timer_nxt;
      for (int i = 0; i < PEER_SLOTS; i++) idle_r[i] <= idle_nxt[i];
    end
  end

  // Address and port of a newly learned slot.
  always_ff @(posedge clk) begin
    if (cmd.execute && learn && (req_r != REQ_TICK)) begin
      ent_addr_r[free_idx] <= addr_r;
      ent_port_r[free_idx] <= port_r;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      act_r     <= act_nxt;
      idx_r     <= idx_nxt;
      hello_r   <= hello_nxt;
      expired_r <= expired_nxt;
      count_r   <= count_nxt;
    end
  end

  assign out_action               = act_r;
  assign out_peer_index           = 3'(idx_r);
  assign out_send_broadcast_hello = hello_r;
  assign out_expired_mask         = 8'(expired_r);
  assign out_peer_count           = 4'(count_r);

  `PLT_ASSERT(a_count_matches, $past(cmd.execute) |-> (int'(count_r) == $countones(used_r)), "peer count differs from used entries")
  `PLT_ASSERT(a_pinned_kept, (cmd.execute && (req_r == REQ_TICK)) |=> ((used_r & pinned_r) == $past(used_r & pinned_r)), "pinned peer lost on tick")
  `PLT_ASSERT(a_tick_only_fields, ($past(cmd.execute) && (act_r != ACT_TICK)) |-> ((expired_r == '0) && !hello_r), "tick fields set on non-tick result")

endmodule

`default_nettype wire

>>> hdl/peer_learning_table_with_aging.sv
// Top level of the peer learning table with ageing.
//
// Items arrive on the in_ ports and transfer at a clock edge where start is
// high and busy is low. An item is a received packet, a tick or a request to
// add a pinned peer. Each item gives one result on the out_ ports, marked by
// out_valid for exactly one cycle, registered with the results as the
// execute state ends. The receiver cannot hold results off; none is needed,
// as one result is delivered per item. No item is taken while busy: the item
// is captured on transfer, then the execute state compares it with all
// entries in parallel and updates table, ageing counters and hello timer.
// Configuration registers are written on the cfg_ channel whenever cfg_valid
// is high; cfg_ready is always high. Write them only while no item is in
// flight. Indexes beyond the register list are accepted and ignored.
// A synchronous active-low reset empties the table, saturates the hello
// timer and restores the configuration defaults; no clearing pass is needed.
`default_nettype none

module peer_learning_table_with_aging #(
  parameter int PEER_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [15:0] in_src_port,
  input  wire logic [31:0] in_first_word,
  input  wire logic [31:0] in_third_word,
  input  wire logic [9:0]  in_packet_length,
  output logic             out_valid,
  output logic [3:0]       out_action,
  output logic [2:0]       out_peer_index,
  output logic             out_send_broadcast_hello,
  output logic [7:0]       out_expired_mask,
  output logic [3:0]       out_peer_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import plt_pkg::*;

  ctrl_cmd_t cmd;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  plt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  plt_datapath #(
    .PEER_SLOTS (PEER_SLOTS)
  ) u_datapath (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .cfg_we                   (cfg_valid && cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .in_req_type              (in_req_type),
    .in_src_addr              (in_src_addr),
    .in_src_port              (in_src_port),
    .in_first_word            (in_first_word),
    .in_third_word            (in_third_word),
    .in_packet_length         (in_packet_length),
    .out_action               (out_action),
    .out_peer_index           (out_peer_index),
    .out_send_broadcast_hello (out_send_broadcast_hello),
    .out_expired_mask         (out_expired_mask),
    .out_peer_count           (out_peer_count)
  );

endmodule

`default_nettype wire
